FILE: rtl/tbps_pkg.sv
package tbps_pkg;

	// Default depth of the waiting-packet queue
	localparam int QUEUE_DEPTH_DEF = 64;

	// Field widths
	localparam int ID_W     = 32;
	localparam int TOKEN_W  = 16;
	localparam int STATUS_W = 3;
	localparam int QCOUNT_W = 7;
	localparam int ENTRY_W  = ID_W + TOKEN_W;

	// Bus widths
	localparam int IN_DATA_W  = ENTRY_W;
	localparam int OUT_DATA_W = 1 + ID_W + TOKEN_W + TOKEN_W + QCOUNT_W;

	// Bucket depth after reset
	localparam logic [TOKEN_W-1:0] DEPTH_RESET = 16'd10;

	// Request kinds
	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_PACKET = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_TOKEN_ADDED   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_TOKEN_DROPPED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_QUEUED        = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_QUEUE_FULL    = 3'd4;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // capture request and read queue head
		logic commit;  // update state and load result register
	} cmd_t;

	// Result payload, first field in the highest bits
	typedef struct packed {
		logic [QCOUNT_W-1:0] queue_count;
		logic [TOKEN_W-1:0]  bucket_level;
		logic [TOKEN_W-1:0]  released_tokens;
		logic [ID_W-1:0]     released_id;
		logic                released;
	} res_t;

endpackage

FILE: rtl/tbps_ctrl.sv
module tbps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output tbps_pkg::cmd_t    cmd
);

	localparam logic [0:0] S_IDLE = 1'b0;
	localparam logic [0:0] S_EXEC = 1'b1;

	logic [0:0] state_q;
	logic       out_valid_q;
	logic       out_free;

	// Accept only when idle; commit once the result register is free
	assign in_ready   = (state_q == S_IDLE);
	assign out_free   = !out_valid_q || out_ready;
	assign cmd.load   = in_valid && in_ready;
	assign cmd.commit = (state_q == S_EXEC) && out_free;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (cmd.commit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			// Result register valid flag
			if (cmd.commit)     out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/tbps_dpath.sv
module tbps_dpath #(
	parameter int QUEUE_DEPTH = tbps_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tbps_pkg::TOKEN_W-1:0]   cfg_wdata,
	input  logic                           in_op,
	input  logic [tbps_pkg::ID_W-1:0]      in_pid,
	input  logic [tbps_pkg::TOKEN_W-1:0]   in_need,
	input  tbps_pkg::cmd_t                 cmd,
	output logic [tbps_pkg::STATUS_W-1:0]  status,
	output tbps_pkg::res_t                 res
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

	// Queue storage: {tokens, id}
	logic [tbps_pkg::ENTRY_W-1:0] mem [QUEUE_DEPTH];
	logic [tbps_pkg::ENTRY_W-1:0] rd_q;

	// Captured request
	logic                         op_q;
	logic [tbps_pkg::ID_W-1:0]    pid_q;
	logic [tbps_pkg::TOKEN_W-1:0] need_q;

	// Shaper state
	logic [tbps_pkg::TOKEN_W-1:0] depth_q;
	logic [tbps_pkg::TOKEN_W-1:0] level_q;
	logic [PW-1:0]                head_q;
	logic [PW-1:0]                tail_q;
	logic [CW-1:0]                cnt_q;

	// Result register
	logic [tbps_pkg::STATUS_W-1:0] status_q;
	tbps_pkg::res_t                res_q;

	logic [tbps_pkg::STATUS_W-1:0] status_d;
	logic [tbps_pkg::TOKEN_W-1:0]  lvl_base;
	logic [tbps_pkg::TOKEN_W-1:0]  lvl_next;
	logic [tbps_pkg::TOKEN_W-1:0]  rel_tok;
	logic [tbps_pkg::ID_W-1:0]     rel_id;
	logic                          rel;
	logic                          push;
	logic [CW-1:0]                 cnt_next;
	logic [PW-1:0]                 head_next;
	logic [PW-1:0]                 tail_next;

	// Step decision
	always_comb begin
		status_d = tbps_pkg::ST_TOKEN_ADDED;
		lvl_base = level_q;
		rel_id   = pid_q;
		rel_tok  = need_q;
		rel      = 1'b0;
		push     = 1'b0;
		if (op_q == tbps_pkg::OP_TICK) begin
			rel_id  = rd_q[tbps_pkg::ID_W-1:0];
			rel_tok = rd_q[tbps_pkg::ENTRY_W-1:tbps_pkg::ID_W];
			if (level_q < depth_q) begin
				lvl_base = level_q + 16'd1;
				status_d = tbps_pkg::ST_TOKEN_ADDED;
			end else begin
				status_d = tbps_pkg::ST_TOKEN_DROPPED;
			end
			rel = (cnt_q != '0) && (rel_tok <= lvl_base);
		end else if (need_q > depth_q) begin
			status_d = tbps_pkg::ST_TOO_LARGE;
		end else if (cnt_q == FULL_CNT) begin
			status_d = tbps_pkg::ST_QUEUE_FULL;
		end else begin
			// Arrival into an empty queue may leave at once
			status_d = tbps_pkg::ST_QUEUED;
			push     = 1'b1;
			rel      = (cnt_q == '0) && (need_q <= level_q);
		end
		lvl_next = rel ? (lvl_base - rel_tok) : lvl_base;
	end

	// Pointer and count updates
	always_comb begin
		head_next = head_q;
		tail_next = tail_q;
		cnt_next  = cnt_q;
		if (rel)  head_next = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
		if (push) tail_next = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
		if (push && !rel)      cnt_next = cnt_q + 1'b1;
		else if (rel && !push) cnt_next = cnt_q - 1'b1;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= tbps_pkg::DEPTH_RESET;
			level_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			cnt_q   <= '0;
		end else begin
			if (cfg_we) depth_q <= cfg_wdata;
			if (cmd.commit) begin
				level_q <= lvl_next;
				head_q  <= head_next;
				tail_q  <= tail_next;
				cnt_q   <= cnt_next;
			end
		end
	end

	// Request capture, queue memory and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_op;
			pid_q  <= in_pid;
			need_q <= in_need;
			rd_q   <= mem[head_q];
		end
		if (cmd.commit && push) mem[tail_q] <= {need_q, pid_q};
		if (cmd.commit) begin
			status_q              <= status_d;
			res_q.released        <= rel;
			res_q.released_id     <= rel ? rel_id : '0;
			res_q.released_tokens <= rel ? rel_tok : '0;
			res_q.bucket_level    <= lvl_next;
			res_q.queue_count     <= tbps_pkg::QCOUNT_W'(cnt_next);
		end
	end

	assign status = status_q;
	assign res    = res_q;

endmodule

FILE: rtl/token_bucket_packet_shaper_core.sv
// Channel   Dir  tdata (low bit up)                               tuser
// s_axis    in   packet_id[31:0], tokens_needed[47:32]             operation
// m_axis    out  released[0], released_id[32:1],                   status
//                released_tokens[48:33], bucket_level[64:49],
//                queue_count[71:65]
// cfg       in   cfg_wdata = token cap of the bucket, written when cfg_we
//
// Each request takes two steps: the first captures it and reads the queue head
// from the synchronous queue memory, the second updates the bucket and queue.
// One request is in work at a time; the next is taken while a result waits.
// A stalled m_axis holds the second step until the result register frees.
// arst_n clears bucket level, queue pointers and count; depth resets to 10.
module token_bucket_packet_shaper_core #(
	parameter int QUEUE_DEPTH = tbps_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tbps_pkg::TOKEN_W-1:0]     cfg_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [tbps_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // packet_id, tokens_needed
	input  logic                             s_axis_tuser,   // operation
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [tbps_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // released, released_id,
	                                                         // released_tokens,
	                                                         // bucket_level, queue_count
	output logic [tbps_pkg::STATUS_W-1:0]    m_axis_tuser    // status
);

	tbps_pkg::cmd_t cmd;
	tbps_pkg::res_t res;

	tbps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	tbps_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_op     (s_axis_tuser),
		.in_pid    (s_axis_tdata[tbps_pkg::ID_W-1:0]),
		.in_need   (s_axis_tdata[tbps_pkg::ENTRY_W-1:tbps_pkg::ID_W]),
		.cmd       (cmd),
		.status    (m_axis_tuser),
		.res       (res)
	);

	assign m_axis_tdata = res;

`ifndef SYNTHESIS
	// A request is never taken while the previous one is in work
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request accepted while another is in work");

	// Commit never overwrites a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result register overwritten");

	// No release means zero id and tokens
	a_rel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !res.released) |->
			(res.released_id == '0 && res.released_tokens == '0))
		else $error("release fields set without a release");

	// Dropped packets never release anything
	a_drop_norel: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == tbps_pkg::ST_TOO_LARGE ||
			m_axis_tuser == tbps_pkg::ST_QUEUE_FULL)) |-> !res.released)
		else $error("release reported with a dropped packet");
`endif

endmodule

FILE: tb/token_bucket_packet_shaper_core_test.sv
module token_bucket_packet_shaper_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QDEPTH      = tbps_pkg::QUEUE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 100000;

	// one expected result: status travels on tuser, the rest on tdata
	typedef struct packed {
		logic [tbps_pkg::STATUS_W-1:0] status;
		tbps_pkg::res_t                res;
	} shaper_result_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [tbps_pkg::TOKEN_W-1:0]    cfg_wdata;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [tbps_pkg::IN_DATA_W-1:0]  s_axis_tdata;   // packet_id, tokens_needed
	logic                            s_axis_tuser;   // operation
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [tbps_pkg::OUT_DATA_W-1:0] m_axis_tdata;   // released, released_id,
	                                                 // released_tokens,
	                                                 // bucket_level, queue_count
	logic [tbps_pkg::STATUS_W-1:0]   m_axis_tuser;   // status

	// shadow state of the shaper
	logic [tbps_pkg::TOKEN_W-1:0] token_cap_now = tbps_pkg::DEPTH_RESET;
	logic [tbps_pkg::TOKEN_W-1:0] bucket_fill   = '0;
	logic [tbps_pkg::ID_W-1:0]    waiting_id   [QDEPTH];
	logic [tbps_pkg::TOKEN_W-1:0] waiting_need [QDEPTH];
	int                           head_slot    = 0;
	int                           tail_slot    = 0;
	int                           queued_count = 0;

	shaper_result_t pending_results[$];

	// traffic shaping of the testbench itself
	int   send_idle_pct = 0;
	int   rx_stall_pct  = 0;
	int   holdoff_len   = 0;
	logic rx_hold       = 1'b0;

	// run statistics
	int cycle_count     = 0;
	int mismatch_count  = 0;
	int request_count   = 0;
	int release_count   = 0;
	int tick_drop_count = 0;
	int too_large_count = 0;
	int full_drop_count = 0;
	int depth_writes    = 0;

	token_bucket_packet_shaper_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #6 clk = ~clk;

	// bucket and queue update for one request, returns the result it should give
	function automatic shaper_result_t shape_request(input logic op,
			input logic [tbps_pkg::ID_W-1:0] pid,
			input logic [tbps_pkg::TOKEN_W-1:0] need);
		shaper_result_t r;
		logic           may_release;
		r           = '0;
		may_release = 1'b0;
		if (op == tbps_pkg::OP_TICK) begin
			if (bucket_fill < token_cap_now) begin
				bucket_fill = bucket_fill + 1'b1;
				r.status    = tbps_pkg::ST_TOKEN_ADDED;
			end else begin
				r.status = tbps_pkg::ST_TOKEN_DROPPED;
			end
			may_release = 1'b1;
		end else if (need > token_cap_now) begin
			r.status = tbps_pkg::ST_TOO_LARGE;
		end else if (queued_count >= QDEPTH) begin
			r.status = tbps_pkg::ST_QUEUE_FULL;
		end else begin
			// only an arrival into an empty queue may leave at once
			may_release             = (queued_count == 0);
			waiting_id[tail_slot]   = pid;
			waiting_need[tail_slot] = need;
			tail_slot               = (tail_slot + 1) % QDEPTH;
			queued_count++;
			r.status = tbps_pkg::ST_QUEUED;
		end
		if (may_release && queued_count != 0 && waiting_need[head_slot] <= bucket_fill) begin
			bucket_fill           = bucket_fill - waiting_need[head_slot];
			r.res.released        = 1'b1;
			r.res.released_id     = waiting_id[head_slot];
			r.res.released_tokens = waiting_need[head_slot];
			head_slot             = (head_slot + 1) % QDEPTH;
			queued_count--;
		end
		r.res.bucket_level = bucket_fill;
		r.res.queue_count  = tbps_pkg::QCOUNT_W'(queued_count);
		return r;
	endfunction

	// token need for a random packet: mostly small, some too large
	function automatic logic [tbps_pkg::TOKEN_W-1:0] pick_need();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 10 && token_cap_now < 16)
			return 16'($urandom);
		else if (roll < 15 && token_cap_now != 16'hFFFF)
			return token_cap_now + 1'b1;
		else
			return 16'($urandom_range(0, 6));
	endfunction

	task automatic report_mismatch(input string what, input shaper_result_t want,
			input logic [tbps_pkg::STATUS_W-1:0] got_status, input tbps_pkg::res_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$write("%0t %s: exp st=%0d rel=%0b id=%h tok=%0d lvl=%0d q=%0d, ",
				$realtime, what, want.status, want.res.released, want.res.released_id,
				want.res.released_tokens, want.res.bucket_level, want.res.queue_count);
			$display("got st=%0d rel=%0b id=%h tok=%0d lvl=%0d q=%0d",
				got_status, got.released, got.released_id, got.released_tokens,
				got.bucket_level, got.queue_count);
		end
	endtask

	// offer one request, wait for it to be taken, then predict its result
	task automatic send_request(input logic op, input logic [tbps_pkg::ID_W-1:0] pid,
			input logic [tbps_pkg::TOKEN_W-1:0] need);
		shaper_result_t want;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {need, pid};
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		want = shape_request(op, pid, need);
		pending_results.push_back(want);
		request_count++;
		if (want.res.released)
			release_count++;
		case (want.status)
			tbps_pkg::ST_TOKEN_DROPPED: tick_drop_count++;
			tbps_pkg::ST_TOO_LARGE:     too_large_count++;
			tbps_pkg::ST_QUEUE_FULL:    full_drop_count++;
			default: ;
		endcase
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// depth is only changed with nothing in flight
	task automatic write_depth(input logic [tbps_pkg::TOKEN_W-1:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		token_cap_now = value;
		depth_writes++;
	endtask

	task automatic send_tick();
		send_request(tbps_pkg::OP_TICK, $urandom, 16'($urandom));
	endtask

	task automatic send_random_request();
		if ($urandom_range(0, 99) < 55)
			send_tick();
		else
			send_request(tbps_pkg::OP_PACKET, $urandom, pick_need());
	endtask

	// edge cases by hand, starting from the reset depth
	task automatic test_basic_cases();
		send_tick();
		send_request(tbps_pkg::OP_PACKET, 32'hFFFF_FFFF, 16'd0);
		send_request(tbps_pkg::OP_PACKET, 32'h0000_0000, 16'hFFFF);
		send_request(tbps_pkg::OP_PACKET, 32'h0000_0001, 16'd3);
		send_request(tbps_pkg::OP_PACKET, 32'h0000_0002, 16'd2);
		// head leaves on the second tick, the next one waits two ticks more
		repeat (4) send_tick();
		// fill to a small depth and overflow
		write_depth(16'd3);
		repeat (4) send_tick();
		// depth below the level: ticks dropped, level kept
		write_depth(16'd1);
		send_tick();
		send_request(tbps_pkg::OP_PACKET, 32'hA5A5_0003, 16'd2);
		send_request(tbps_pkg::OP_PACKET, 32'h5A5A_0004, 16'd1);
		write_depth(16'd0);
		send_tick();
		send_request(tbps_pkg::OP_PACKET, 32'h1234_5678, 16'd0);
		// queued packet above the lowered depth stays until the level covers it
		write_depth(16'd5);
		send_request(tbps_pkg::OP_PACKET, 32'h8765_4321, 16'd5);
		write_depth(16'd2);
		repeat (2) send_tick();
		write_depth(16'hFFFF);
		repeat (3) send_tick();
		write_depth(16'hFFFE);
		send_request(tbps_pkg::OP_PACKET, 32'hDEAD_0005, 16'hFFFF);
		send_request(tbps_pkg::OP_PACKET, 32'h0000_0006, 16'd0);
	endtask

	// fill every queue slot, overflow it, then drain with ticks
	task automatic test_queue_full();
		write_depth(bucket_fill + 16'd3);
		send_request(tbps_pkg::OP_PACKET, $urandom, bucket_fill + 16'd1);
		repeat (QDEPTH - 1)
			send_request(tbps_pkg::OP_PACKET, $urandom, 16'($urandom_range(0, 2)));
		repeat (2)
			send_request(tbps_pkg::OP_PACKET, $urandom, 16'($urandom_range(0, 2)));
		// the size test wins over the full test
		send_request(tbps_pkg::OP_PACKET, $urandom, token_cap_now + 16'd1);
		write_depth(16'hFFFF);
		while (queued_count != 0)
			send_tick();
	endtask

	task automatic run_random_phase(input int n_items,
			input logic [tbps_pkg::TOKEN_W-1:0] new_depth,
			input int tx_idle, input int rx_stall);
		write_depth(new_depth);
		send_idle_pct = tx_idle;
		rx_stall_pct <= rx_stall;
		repeat (n_items)
			send_random_request();
	endtask

	task automatic test_random_mix();
		run_random_phase(50, 16'($urandom_range(2, 12)), 0, 0);
		run_random_phase(50, 16'd1, 69, 0);
		run_random_phase(50, 16'hFFFF, 0, 69);
		run_random_phase(50, 16'($urandom_range(13, 65535)), 14, 14);
	endtask

	// result side held off while requests keep coming, so the input backs up
	task automatic test_output_backpressure();
		write_depth(16'($urandom_range(2, 12)));
		send_idle_pct = 0;
		rx_stall_pct <= 0;
		holdoff_len  <= 200;
		repeat (30)
			send_random_request();
	endtask

	// long receiver hold-off, counted here
	initial begin : rx_holdoff
		forever begin
			@(posedge clk);
			if (holdoff_len != 0) begin
				rx_hold <= 1'b1;
				repeat (holdoff_len) @(posedge clk);
				rx_hold     <= 1'b0;
				holdoff_len <= 0;
			end
		end
	end

	// result checker and receiver ready
	always @(posedge clk) begin : result_check
		tbps_pkg::res_t got;
		shaper_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", '0, m_axis_tuser, got);
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tuser !== want.status
						|| got.released !== want.res.released
						|| got.released_id !== want.res.released_id
						|| got.released_tokens !== want.res.released_tokens
						|| got.bucket_level !== want.res.bucket_level
						|| got.queue_count !== want.res.queue_count)
					report_mismatch("result mismatch", want, m_axis_tuser, got);
			end
		end
		m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = tbps_pkg::OP_TICK;
		m_axis_tready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_cases();
		test_queue_full();
		test_random_mix();
		test_output_backpressure();

		drain_results();
		repeat (8) @(posedge clk);
		$display("Ran %0d requests over %0d depth settings: %0d releases, %0d dropped ticks",
			request_count, depth_writes, release_count, tick_drop_count);
		$display("Drops: %0d oversize, %0d queue full; %0d mismatches",
			too_large_count, full_drop_count, mismatch_count);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
